>>> rtl/mpd_pkg.sv
package mpd_pkg;

    localparam int MESSAGE_BITS = 16;
    localparam int HC_W         = 7;
    localparam int POS_W        = 6;
    localparam int UNIT_W       = 13;
    localparam int TICKS_W      = 15;
    localparam int HALVES       = 4;
    localparam int HALF_CNT_W   = 3;

    localparam logic [HC_W-1:0]  DONE_MARK = HC_W'(2 * MESSAGE_BITS - 1);
    localparam logic [POS_W-1:0] LAST_POS  = POS_W'(MESSAGE_BITS - 1);

    localparam logic [UNIT_W-1:0] UNIT_RESET = UNIT_W'(1000);
    localparam logic [UNIT_W-1:0] TOL_RESET  = UNIT_W'(250);

    // Configuration register indexes
    localparam logic CFG_UNIT = 1'b0;
    localparam logic CFG_TOL  = 1'b1;

    // One classified symbol: the half-bit levels it contributes, in order.
    typedef struct packed {
        logic                  frame_start;
        logic [HALF_CNT_W-1:0] half_cnt;
        logic [HALVES-1:0]     levels;
    } entry_t;

    typedef struct packed {
        logic             data_bit;
        logic [POS_W-1:0] bit_position;
        logic             message_done;
        logic             item_last;
    } result_t;

endpackage

>>> rtl/mpd_front.sv
module mpd_front
    import mpd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic               cfg_index,
    input  logic [UNIT_W-1:0]  cfg_data,
    input  logic               frame_start,
    input  logic               first_level,
    input  logic [TICKS_W-1:0] first_ticks,
    input  logic               second_level,
    input  logic [TICKS_W-1:0] second_ticks,
    output entry_t             entry
);

    logic [UNIT_W-1:0]  unit_reg;
    logic [UNIT_W-1:0]  tol_reg;
    logic [TICKS_W:0]   spec2;
    logic [TICKS_W:0]   spec4;
    logic               win0;
    logic               win1;
    logic               win_lead;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_reg <= UNIT_RESET;
            tol_reg  <= TOL_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_UNIT: unit_reg <= cfg_data;
                CFG_TOL:  tol_reg  <= cfg_data;
                default:  unit_reg <= unit_reg;
            endcase
        end
    end

    assign spec2 = {2'b00, unit_reg, 1'b0};
    assign spec4 = {1'b0, unit_reg, 2'b00};

    // Strict window: spec - tol < ticks < spec + tol, kept free of negatives.
    function automatic logic in_window(input logic [TICKS_W-1:0] ticks,
                                       input logic [TICKS_W:0]   spec,
                                       input logic [UNIT_W-1:0]  tol);
        logic [TICKS_W+1:0] lhs;
        logic [TICKS_W+1:0] rhs;
        lhs = {2'b00, ticks} + {4'b0000, tol};
        rhs = {1'b0, spec} + {4'b0000, tol};
        return (lhs > {1'b0, spec}) && ({2'b00, ticks} < rhs);
    endfunction

    assign win0     = in_window(first_ticks, spec2, tol_reg);
    assign win1     = in_window(second_ticks, spec2, tol_reg);
    assign win_lead = in_window(second_ticks, spec4, tol_reg);

    always_comb
    begin
        entry.frame_start = frame_start;
        entry.levels      = '0;
        entry.half_cnt    = '0;
        if (frame_start)
        begin
            entry.levels[0] = second_level;
            entry.half_cnt  = win_lead ? HALF_CNT_W'(1) : HALF_CNT_W'(0);
        end
        else
        begin
            entry.levels[0] = first_level;
            if (win0)
            begin
                entry.levels[1] = first_level;
                entry.levels[2] = second_level;
                entry.levels[3] = second_level;
            end
            else
            begin
                entry.levels[1] = second_level;
                entry.levels[2] = second_level;
            end
            entry.half_cnt = HALF_CNT_W'(2) + HALF_CNT_W'(win0) + HALF_CNT_W'(win1);
        end
    end

endmodule

>>> rtl/mpd_fifo.sv
module mpd_fifo
    import mpd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_data,
    output logic   full,
    input  logic   pop,
    output entry_t pop_data,
    output logic   not_empty
);

    entry_t     mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

>>> rtl/mpd_back.sv
module mpd_back
    import mpd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    entry_valid,
    input  entry_t  entry,
    output logic    entry_pop,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);

    logic [HC_W-1:0] hc_reg;
    logic [HC_W-1:0] hc_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    result_t         out_reg;
    result_t         out_next;
    logic            sec_valid_reg;
    logic            sec_valid_next;
    result_t         sec_reg;
    result_t         sec_next;
    result_t         r0;
    result_t         r1;
    logic [1:0]      n_res;
    logic            out_free;

    // Walk the symbol's half-bits; every even position yields one bit.
    always_comb
    begin
        logic [HC_W-1:0] hc;
        hc    = entry.frame_start ? '0 : hc_reg;
        n_res = 2'd0;
        r0    = '0;
        r1    = '0;
        for (int i = 0; i < HALVES; i++)
        begin
            if ((HALF_CNT_W'(i) < entry.half_cnt) && (hc < DONE_MARK))
            begin
                if (!hc[0])
                begin
                    if (n_res == 2'd0)
                    begin
                        r0.data_bit     = entry.levels[i];
                        r0.bit_position = hc[HC_W-1:1];
                        r0.message_done = (hc[HC_W-1:1] == LAST_POS);
                    end
                    else
                    begin
                        r1.data_bit     = entry.levels[i];
                        r1.bit_position = hc[HC_W-1:1];
                        r1.message_done = (hc[HC_W-1:1] == LAST_POS);
                    end
                    n_res = n_res + 2'd1;
                    hc    = (hc[HC_W-1:1] == LAST_POS) ? DONE_MARK : hc + HC_W'(1);
                end
                else
                begin
                    hc = hc + HC_W'(1);
                end
            end
        end
        r0.item_last = (n_res == 2'd1);
        r1.item_last = 1'b1;
        hc_next      = hc;
    end

    assign out_free  = !out_valid_reg || res_ready;
    assign entry_pop = entry_valid && !sec_valid_reg && out_free;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        sec_valid_next = sec_valid_reg;
        sec_next       = sec_reg;
        if (entry_pop)
        begin
            out_valid_next = (n_res != 2'd0);
            out_next       = r0;
            sec_valid_next = (n_res == 2'd2);
            sec_next       = r1;
        end
        else if (out_free)
        begin
            // Second bit of the symbol moves up as soon as the first beat leaves.
            out_valid_next = sec_valid_reg;
            out_next       = sec_reg;
            sec_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        sec_reg <= sec_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hc_reg        <= '0;
            out_valid_reg <= 1'b0;
            sec_valid_reg <= 1'b0;
        end
        else
        begin
            if (entry_pop)
            begin
                hc_reg <= hc_next;
            end
            out_valid_reg <= out_valid_next;
            sec_valid_reg <= sec_valid_next;
        end
    end

endmodule

>>> rtl/manchester_pulse_decoder.sv
// A symbol accepted into the queue passes the queue register and then the output register
// before its first decoded bit appears on the output.
// Throughput: one symbol per cycle while it yields at most one bit and out_ready is high;
// the back part takes no symbol while a second bit of the last one still waits.
// A two-entry queue separates symbol classification from the bit counter.
// Reset clears the queue, the output and the half-bit count; timings go to 1000 and 250.
module manchester_pulse_decoder
    import mpd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [UNIT_W-1:0]  cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               frame_start,
    input  logic               first_level,
    input  logic [TICKS_W-1:0] first_ticks,
    input  logic               second_level,
    input  logic [TICKS_W-1:0] second_ticks,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               data_bit,
    output logic [POS_W-1:0]   bit_position,
    output logic               message_done,
    output logic               item_last
);

    entry_t  front_entry;
    entry_t  queue_entry;
    logic    queue_full;
    logic    queue_not_empty;
    logic    queue_pop;
    logic    push;
    result_t res;

    assign cfg_ready = 1'b1;
    assign in_ready  = !queue_full;
    assign push      = in_valid && !queue_full;

    mpd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .frame_start  (frame_start),
        .first_level  (first_level),
        .first_ticks  (first_ticks),
        .second_level (second_level),
        .second_ticks (second_ticks),
        .entry        (front_entry)
    );

    mpd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_entry),
        .full      (queue_full),
        .pop       (queue_pop),
        .pop_data  (queue_entry),
        .not_empty (queue_not_empty)
    );

    mpd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry_valid (queue_not_empty),
        .entry       (queue_entry),
        .entry_pop   (queue_pop),
        .res_valid   (out_valid),
        .res_ready   (out_ready),
        .res         (res)
    );

    assign data_bit     = res.data_bit;
    assign bit_position = res.bit_position;
    assign message_done = res.message_done;
    assign item_last    = res.item_last;

endmodule
